// ----- rtl/fr_pkg.sv -----
package fr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned DEN_W  = 31;
  localparam int unsigned CNT_W  = 5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [WORD_W-1:0] numerator_in;
    logic signed [WORD_W-1:0] denominator_in;
  } fr_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] numerator_out;
    logic [DEN_W-1:0]         denominator_out;
    logic [1:0]               status;
  } fr_out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic norm_step;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic finish;
  } fr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic zero_case;
    logic both_even;
    logic gcd_done;
    logic div_last;
    logic out_free;
  } fr_sts_t;

endpackage

// ----- rtl/fr_ctrl.sv -----
module fr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fr_pkg::fr_sts_t sts,
  output fr_pkg::fr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_NORM  = 3'd2;
  localparam logic [2:0] S_GCD   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.zero_case) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        // strip common factors of two first
        if (sts.both_even) begin
          cmd.norm_step = 1'b1;
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/fr_datapath.sv -----
module fr_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  fr_pkg::fr_in_t  in_data,
  input  fr_pkg::fr_cmd_t cmd,
  output fr_pkg::fr_sts_t sts,
  output logic            out_valid,
  input  logic            out_stall,
  output fr_pkg::fr_out_t out_data
);

  localparam int unsigned W = fr_pkg::WORD_W;

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
    return v[W-1] ? (~v + W'(1)) : v;
  endfunction

  // one restoring division bit: returns {remainder, quotient shift register}
  function automatic logic [2*W-1:0] div_bit(input logic [W-1:0] rem,
                                             input logic [W-1:0] q,
                                             input logic [W-1:0] dvs);
    logic [W:0] trial;
    logic [W:0] diff;
    trial = {rem, q[W-1]};
    diff  = trial - {1'b0, dvs};
    if (!diff[W]) begin
      return {diff[W-1:0], q[W-2:0], 1'b1};
    end
    return {trial[W-1:0], q[W-2:0], 1'b0};
  endfunction

  logic [W-1:0]              a_r, a_nxt, b_r, b_nxt;
  logic [W-1:0]              mn_r, mn_nxt, md_r, md_nxt;
  logic [W-1:0]              g_r, g_nxt;
  logic [W-1:0]              qn_r, qn_nxt, qd_r, qd_nxt;
  logic [W-1:0]              rn_r, rn_nxt, rd_r, rd_nxt;
  logic [fr_pkg::CNT_W-1:0]  k_r, k_nxt, cnt_r, cnt_nxt;
  logic                      zn_r, zn_nxt, zd_r, zd_nxt, neg_r, neg_nxt;
  logic                      out_valid_r, out_valid_nxt;
  fr_pkg::fr_out_t           out_r, out_nxt;
  logic [W-1:0]              diff_ab, diff_ba;
  logic [2*W-1:0]            div_n, div_d;

  assign diff_ab = a_r - b_r;
  assign diff_ba = b_r - a_r;
  assign div_n   = div_bit(rn_r, qn_r, g_r);
  assign div_d   = div_bit(rd_r, qd_r, g_r);

  assign sts.zero_case = zn_r | zd_r;
  assign sts.both_even = ~a_r[0] & ~b_r[0];
  assign sts.gcd_done  = (a_r == b_r);
  assign sts.div_last  = (cnt_r == {fr_pkg::CNT_W{1'b1}});
  assign sts.out_free  = ~out_valid_r | ~out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    mn_nxt  = mn_r;
    md_nxt  = md_r;
    g_nxt   = g_r;
    qn_nxt  = qn_r;
    qd_nxt  = qd_r;
    rn_nxt  = rn_r;
    rd_nxt  = rd_r;
    k_nxt   = k_r;
    cnt_nxt = cnt_r;
    zn_nxt  = zn_r;
    zd_nxt  = zd_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      a_nxt   = magnitude(in_data.numerator_in);
      b_nxt   = magnitude(in_data.denominator_in);
      mn_nxt  = magnitude(in_data.numerator_in);
      md_nxt  = magnitude(in_data.denominator_in);
      k_nxt   = '0;
      zn_nxt  = (in_data.numerator_in == '0);
      zd_nxt  = (in_data.denominator_in == '0);
      neg_nxt = in_data.numerator_in[W-1] ^ in_data.denominator_in[W-1];
    end
    if (cmd.norm_step) begin
      a_nxt = a_r >> 1;
      b_nxt = b_r >> 1;
      k_nxt = k_r + fr_pkg::CNT_W'(1);
    end
    if (cmd.gcd_step) begin
      // binary gcd: odd minus odd is even, so shift right in the same step
      if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r > b_r) begin
        a_nxt = diff_ab >> 1;
      end else begin
        b_nxt = diff_ba >> 1;
      end
    end
    if (cmd.div_init) begin
      g_nxt   = a_r << k_r;
      qn_nxt  = mn_r;
      qd_nxt  = md_r;
      rn_nxt  = '0;
      rd_nxt  = '0;
      cnt_nxt = '0;
    end
    if (cmd.div_step) begin
      rn_nxt  = div_n[2*W-1:W];
      qn_nxt  = div_n[W-1:0];
      rd_nxt  = div_d[2*W-1:W];
      qd_nxt  = div_d[W-1:0];
      cnt_nxt = cnt_r + fr_pkg::CNT_W'(1);
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
      if (zd_r) begin
        out_nxt.numerator_out   = '0;
        out_nxt.denominator_out = '0;
        out_nxt.status          = fr_pkg::ST_ZERO_DEN;
      end else if (zn_r) begin
        out_nxt.numerator_out   = '0;
        out_nxt.denominator_out = fr_pkg::DEN_W'(1);
        out_nxt.status          = fr_pkg::ST_OK;
      end else if (qn_r[W-1] || qd_r[W-1]) begin
        out_nxt.numerator_out   = '0;
        out_nxt.denominator_out = '0;
        out_nxt.status          = fr_pkg::ST_OVERFLOW;
      end else begin
        out_nxt.numerator_out   = neg_r ? (W'(0) - qn_r) : qn_r;
        out_nxt.denominator_out = qd_r[fr_pkg::DEN_W-1:0];
        out_nxt.status          = fr_pkg::ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    mn_r  <= mn_nxt;
    md_r  <= md_nxt;
    g_r   <= g_nxt;
    qn_r  <= qn_nxt;
    qd_r  <= qd_nxt;
    rn_r  <= rn_nxt;
    rd_r  <= rd_nxt;
    k_r   <= k_nxt;
    cnt_r <= cnt_nxt;
    zn_r  <= zn_nxt;
    zd_r  <= zd_nxt;
    neg_r <= neg_nxt;
    out_r <= out_nxt;
  end

endmodule

// ----- rtl/fraction_reducer_core.sv -----
// Reduces a signed fraction to lowest terms, one item at a time. The sign goes
// on numerator_out and denominator_out is positive; a zero denominator gives
// status 1 with 0/0, a zero numerator gives 0/1, and a result needing 2^31
// gives status 2 with 0/0. After acceptance a check state sends the zero
// cases straight to writing the result; otherwise the block removes common
// factors of two, runs binary-gcd subtract-and-shift steps, divides both
// magnitudes by the gcd with bit-serial restoring division, and then writes
// the result to the output register. in_stall is high from acceptance until
// the result is placed in the output register, which holds it while out_stall
// is high; a result that is still waiting holds the next one back.
module fraction_reducer_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fr_pkg::fr_in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output fr_pkg::fr_out_t out_data
);

  fr_pkg::fr_cmd_t cmd;
  fr_pkg::fr_sts_t sts;

  fr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // an accepted item keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input reopened right after accepting an item");

  // a result is only written when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || !out_stall))
    else $error("result written over a stalled result");

  a_ok_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == fr_pkg::ST_OK |-> out_data.denominator_out != '0)
    else $error("ok result with zero denominator");

  a_err_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != fr_pkg::ST_OK |->
      out_data.numerator_out == '0 && out_data.denominator_out == '0)
    else $error("error result with nonzero fields");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam logic signed [fr_pkg::WORD_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [fr_pkg::WORD_W-1:0] INT_MAX = 32'sh7fff_ffff;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 200;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_START   = 400;
  localparam int HOLD_CYCLES  = 600;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  fr_pkg::fr_in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  fr_pkg::fr_out_t out_data;

  fr_pkg::fr_in_t  pending_fracs[$];
  fr_pkg::fr_out_t expected_reduced[$];
  fr_pkg::fr_out_t want;
  int      error_count = 0;
  int      accepted_cnt = 0;
  int      burst_left = 0;
  int      gap_left = 0;
  int      stretch_left = 0;
  int      stall_mode = 0;
  int      hold_left = 0;
  bit      hold_done = 1'b0;
  int      idle_cycles = 0;

  fraction_reducer_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lowest terms via euclid on unsigned magnitudes
  function automatic fr_pkg::fr_out_t reduce_fraction(fr_pkg::fr_in_t f);
    logic [fr_pkg::WORD_W-1:0] num, den, mag_n, mag_d, a, b, r;
    logic                      neg;
    fr_pkg::fr_out_t           res;
    num = f.numerator_in;
    den = f.denominator_in;
    neg = num[fr_pkg::WORD_W-1] ^ den[fr_pkg::WORD_W-1];
    res = '0;
    if (den == '0) begin
      res.status = fr_pkg::ST_ZERO_DEN;
      return res;
    end
    if (num == '0) begin
      res.denominator_out = fr_pkg::DEN_W'(1);
      res.status = fr_pkg::ST_OK;
      return res;
    end
    mag_n = num[fr_pkg::WORD_W-1] ? (~num + 32'd1) : num;
    mag_d = den[fr_pkg::WORD_W-1] ? (~den + 32'd1) : den;
    a = mag_n;
    b = mag_d;
    while (b != '0) begin
      r = a % b;
      a = b;
      b = r;
    end
    mag_n = mag_n / a;
    mag_d = mag_d / a;
    if (mag_n[fr_pkg::WORD_W-1] || mag_d[fr_pkg::WORD_W-1]) begin
      res.status = fr_pkg::ST_OVERFLOW;
      return res;
    end
    res.numerator_out   = neg ? (~mag_n + 32'd1) : mag_n;
    res.denominator_out = mag_d[fr_pkg::DEN_W-1:0];
    res.status          = fr_pkg::ST_OK;
    return res;
  endfunction

  function automatic logic signed [fr_pkg::WORD_W-1:0] rand_sign(
    logic signed [fr_pkg::WORD_W-1:0] v
  );
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic signed [fr_pkg::WORD_W-1:0] pick_special();
    case ($urandom_range(0, 6))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return INT_MIN;
      4: return INT_MAX;
      5: return INT_MIN + 1;
      default: return 32'sh4000_0000;
    endcase
  endfunction

  function automatic fr_pkg::fr_in_t make_fraction();
    fr_pkg::fr_in_t f;
    int unsigned    pick, g, k;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      f.numerator_in   = $urandom();
      f.denominator_in = $urandom();
    end else if (pick < 55) begin
      // shared odd-or-even factor times two cofactors
      g = $urandom_range(1, 65535);
      f.numerator_in   = rand_sign(g * $urandom_range(1, 32767));
      f.denominator_in = rand_sign(g * $urandom_range(1, 32767));
    end else if (pick < 70) begin
      // common power of two, stresses the shift stage
      k = $urandom_range(0, 30);
      f.numerator_in   = rand_sign(($urandom() >> (k + 1)) << k);
      f.denominator_in = rand_sign(($urandom() >> (k + 1)) << k);
    end else if (pick < 80) begin
      f.numerator_in   = $signed($urandom_range(0, 128)) - 64;
      f.denominator_in = $signed($urandom_range(0, 128)) - 64;
    end else if (pick < 90) begin
      f.numerator_in   = $urandom_range(0, 1) ? pick_special() : $urandom();
      f.denominator_in = $urandom_range(0, 1) ? pick_special() : $urandom();
    end else begin
      // one side divides the other
      g = $urandom_range(1, 1 << 20);
      k = $urandom_range(1, 2047);
      if ($urandom_range(0, 1)) begin
        f.numerator_in   = rand_sign(g);
        f.denominator_in = rand_sign(g * k);
      end else begin
        f.numerator_in   = rand_sign(g * k);
        f.denominator_in = rand_sign(g);
      end
    end
    return f;
  endfunction

  function automatic int next_gap();
    int unsigned pick;
    pick = $urandom_range(0, 3);
    if (pick == 0) return 0;
    if (pick == 3) return $urandom_range(9, 160);
    return $urandom_range(1, 8);
  endfunction

  task automatic add_fraction(logic signed [fr_pkg::WORD_W-1:0] n,
                              logic signed [fr_pkg::WORD_W-1:0] d);
    fr_pkg::fr_in_t f;
    f.numerator_in   = n;
    f.denominator_in = d;
    pending_fracs.push_back(f);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_data    <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_reduced.push_back(reduce_fraction(in_data));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_fracs.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_fracs.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 60);
            gap_left   <= next_gap();
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // receiver stall pattern, with one long hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && accepted_cnt >= HOLD_START) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stretch_left == 0) begin
      stall_mode   <= $urandom_range(0, 2);
      stretch_left <= $urandom_range(5, 200);
      out_stall    <= 1'b0;
    end else begin
      stretch_left <= stretch_left - 1;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reduced.size() == 0) begin
        $error("unexpected item: %0d/%0d status %0d", out_data.numerator_out,
               out_data.denominator_out, out_data.status);
        error_count++;
      end else begin
        want = expected_reduced.pop_front();
        if (out_data.numerator_out !== want.numerator_out) begin
          $error("numerator_out: expected %0d, got %0d", want.numerator_out,
                 out_data.numerator_out);
          error_count++;
        end
        if (out_data.denominator_out !== want.denominator_out) begin
          $error("denominator_out: expected %0d, got %0d", want.denominator_out,
                 out_data.denominator_out);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // zero denominator wins over zero numerator
    add_fraction(0, 0);
    add_fraction(5, 0);
    add_fraction(-7, 0);
    add_fraction(INT_MIN, 0);
    add_fraction(0, 5);
    add_fraction(0, -5);
    add_fraction(0, INT_MIN);
    add_fraction(0, INT_MAX);
    // magnitude overflow from the most negative input, then cases that reduce normally
    add_fraction(INT_MIN, 1);
    add_fraction(INT_MIN, -1);
    add_fraction(1, INT_MIN);
    add_fraction(-1, INT_MIN);
    add_fraction(INT_MIN, INT_MAX);
    add_fraction(INT_MAX, INT_MIN);
    add_fraction(INT_MIN, INT_MIN);
    add_fraction(INT_MIN, 2);
    add_fraction(2, INT_MIN);
    add_fraction(INT_MAX, INT_MAX);
    add_fraction(INT_MAX, -INT_MAX);
    add_fraction(-INT_MAX, -INT_MAX);
    add_fraction(6, -4);
    add_fraction(-6, -4);
    add_fraction(12, 18);
    add_fraction(32'sh4000_0000, 32'sh2000_0000);
    add_fraction(INT_MAX, INT_MAX - 1);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pending_fracs.push_back(make_fraction());
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_fracs.size() != 0 || in_valid || expected_reduced.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
